@@ sv/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Field widths, operation and register codes, saturation limits and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mme_pkg;

    // payload widths fixed by the interface
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // input operation codes
    localparam logic OP_LOAD_A = 1'b0;
    localparam logic OP_LOAD_B = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    // configuration reset value
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // saturation limits in Q16.16
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // controller to datapath commands
    typedef struct packed {
        logic             load_left;   // write element into left store
        logic             load_right;  // write element into right store
        logic             mac_valid;   // issue one multiply-accumulate term
        logic             mac_first;   // first term of an entry
        logic             mac_last;    // last term of an entry
        logic             emit;        // move finished entry to output
        logic             emit_err;    // emit a dimension mismatch result
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic res_ready;  // finished entry waiting
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

endpackage

@@ sv/matrix_multiply_engine.sv @@
// Elements are taken one per cycle while the engine is idle.
// After the completing element, each product entry runs its K terms (K = inner
// dimension) through the single multiply-accumulate unit, followed by store read,
// multiply, accumulate and saturation; entries are produced one after another.
// A mismatch result goes through the error state into the output register once it is free.
// Reset clears control, fill counts and dimensions (8); stores are not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_engine: Q16.16 dense matrix multiplication
// Loads A and B element by element, then emits C = A * B in row-major order
// with saturation flags, or one error result when inner dimensions differ.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic signed [DATA_W-1:0] i_element_value,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_product_value,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic                     o_saturated,
    output logic                     o_status,
    output logic                     o_last
);

    localparam int FILL_W = $clog2(MAX_DIM * MAX_DIM + 1);

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [FILL_W-1:0] wr_addr, left_addr, right_addr;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_op         (i_op),
        .o_in_stall   (o_in_stall),
        .o_cmd        (dp_cmd),
        .o_wr_addr    (wr_addr),
        .o_left_addr  (left_addr),
        .o_right_addr (right_addr),
        .i_stat       (dp_stat)
    );

    mme_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_element_value (i_element_value),
        .i_wr_addr       (wr_addr),
        .i_left_addr     (left_addr),
        .i_right_addr    (right_addr),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_product_value (o_product_value),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_saturated     (o_saturated),
        .o_status        (o_status),
        .o_last          (o_last)
    );

`ifndef ASSERT_OFF
    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.emit || dp_cmd.emit_err) |-> dp_stat.out_free)
        else $error("result loaded into a busy output register");

    // no element is taken while product terms are being issued
    a_no_load_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !dp_cmd.mac_valid)
        else $error("element accepted during multiply");

    // a mismatch result is a lone, last, all-zero result
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_MISMATCH) |->
        (o_last && o_product_value == '0 && !o_saturated))
        else $error("malformed mismatch result");

    // a clipped entry holds one of the two limits
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        (o_product_value == SAT_MAX || o_product_value == SAT_MIN))
        else $error("saturated entry not at a limit");
`endif

endmodule

@@ sv/mme_ctrl.sv @@
// ----------------------------------------------------------------------------
// mme_ctrl: sequencer of the matrix multiply engine
// Holds the dimension registers and fill counts, takes elements, and walks
// row, column and inner index of the product; one term per cycle, none in S_WAIT.
// ----------------------------------------------------------------------------
module mme_ctrl
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input item handshake
    input  logic                 i_in_valid,
    input  logic                 i_op,
    output logic                 o_in_stall,
    // datapath control
    output t_dp_cmd              o_cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] o_wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] o_left_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] o_right_addr,
    input  t_dp_stat             i_stat
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int FILL_W = $clog2(MAX_DIM * MAX_DIM + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_ERR  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [FILL_W-1:0] r_lfill, n_lfill, r_rfill, n_rfill;
    logic [DIM_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [FILL_W-1:0] r_lbase, n_lbase, r_la, n_la, r_ra, n_ra;

    logic [DIM_W-1:0]  ar, ac, br, bc;
    logic [FILL_W-1:0] lsize, rsize;
    logic              in_xfer;
    logic              k_last, j_last, i_last;

    // register value 0 reads as 1, above MAX_DIM reads as MAX_DIM
    function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    assign ar    = dim_of(r_a_rows);
    assign ac    = dim_of(r_a_cols);
    assign br    = dim_of(r_b_rows);
    assign bc    = dim_of(r_b_cols);
    assign lsize = FILL_W'(FILL_W'(ar) * FILL_W'(ac));
    assign rsize = FILL_W'(FILL_W'(br) * FILL_W'(bc));

    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign k_last = (r_k == ac - DIM_W'(1));
    assign j_last = (r_j == bc - DIM_W'(1));
    assign i_last = (r_i == ar - DIM_W'(1));

    assign o_wr_addr    = (i_op == OP_LOAD_B) ? r_rfill : r_lfill;
    assign o_left_addr  = r_la;
    assign o_right_addr = r_ra;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= CFG_RESET;
            r_a_cols <= CFG_RESET;
            r_b_rows <= CFG_RESET;
            r_b_cols <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_A_ROWS: r_a_rows <= i_cfg_data;
                REG_A_COLS: r_a_cols <= i_cfg_data;
                REG_B_ROWS: r_b_rows <= i_cfg_data;
                REG_B_COLS: r_b_cols <= i_cfg_data;
            endcase
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_lfill = r_lfill;
        n_rfill = r_rfill;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_lbase = r_lbase;
        n_la    = r_la;
        n_ra    = r_ra;
        o_cmd   = '0;
        o_cmd.row  = IDX_W'(r_i);
        o_cmd.col  = IDX_W'(r_j);
        o_cmd.last = i_last && j_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // store the element unless its matrix is already full
                    if (i_op == OP_LOAD_A && r_lfill < lsize) begin
                        o_cmd.load_left = 1'b1;
                        n_lfill = r_lfill + FILL_W'(1);
                    end else if (i_op == OP_LOAD_B && r_rfill < rsize) begin
                        o_cmd.load_right = 1'b1;
                        n_rfill = r_rfill + FILL_W'(1);
                    end
                    // both matrices complete: start over and multiply
                    if (n_lfill >= lsize && n_rfill >= rsize) begin
                        n_lfill = '0;
                        n_rfill = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_lbase = '0;
                        n_la    = '0;
                        n_ra    = '0;
                        n_state = (ac != br) ? S_ERR : S_MAC;
                    end
                end
            end
            S_MAC: begin
                // one product term per cycle
                o_cmd.mac_valid = 1'b1;
                o_cmd.mac_first = (r_k == '0);
                o_cmd.mac_last  = k_last;
                n_k  = r_k + DIM_W'(1);
                n_la = r_la + FILL_W'(1);
                n_ra = r_ra + FILL_W'(bc);
                if (k_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_stat.res_ready && i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_k = '0;
                    if (i_last && j_last) begin
                        n_state = S_IDLE;
                    end else if (j_last) begin
                        // next row
                        n_i     = r_i + DIM_W'(1);
                        n_j     = '0;
                        n_lbase = r_lbase + FILL_W'(ac);
                        n_la    = r_lbase + FILL_W'(ac);
                        n_ra    = '0;
                        n_state = S_MAC;
                    end else begin
                        n_j     = r_j + DIM_W'(1);
                        n_la    = r_lbase;
                        n_ra    = FILL_W'(r_j) + FILL_W'(1);
                        n_state = S_MAC;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lfill <= '0;
            r_rfill <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_lbase <= '0;
            r_la    <= '0;
            r_ra    <= '0;
        end else begin
            r_state <= n_state;
            r_lfill <= n_lfill;
            r_rfill <= n_rfill;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_lbase <= n_lbase;
            r_la    <= n_la;
            r_ra    <= n_ra;
        end
    end

endmodule

@@ sv/mme_dp.sv @@
// ----------------------------------------------------------------------------
// mme_dp: datapath of the matrix multiply engine
// Element stores, registered read, one 32x32 multiplier, wide accumulator,
// shift and saturation, and the output register.
// ----------------------------------------------------------------------------
module mme_dp
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // element write
    input  logic signed [DATA_W-1:0] i_element_value,
    input  logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] i_wr_addr,
    // read addresses
    input  logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] i_left_addr,
    input  logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] i_right_addr,
    // control
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    // result channel
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic signed [DATA_W-1:0] o_product_value,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic                     o_saturated,
    output logic                     o_status,
    output logic                     o_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_DIM);

    logic [DATA_W-1:0]        r_lmem [DEPTH];
    logic [DATA_W-1:0]        r_rmem [DEPTH];
    logic signed [DATA_W-1:0] r_l_q, r_r_q;
    logic                     r_s1_v, r_s1_first, r_s1_last;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_s2_v, r_s2_first, r_s2_last;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_acc_done;
    logic [DATA_W-1:0]        r_res, n_res;
    logic                     r_res_sat, n_res_sat;
    logic                     r_res_ready;
    logic                     r_out_valid;

    logic signed [ACC_W-1:0]    shifted;
    logic [ACC_W-DATA_W:0]      upper;
    logic                       fits;

    // element stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_left) begin
            r_lmem[i_wr_addr[ADDR_W-1:0]] <= i_element_value;
        end
        if (i_cmd.load_right) begin
            r_rmem[i_wr_addr[ADDR_W-1:0]] <= i_element_value;
        end
        r_l_q <= r_lmem[i_left_addr[ADDR_W-1:0]];
        r_r_q <= r_rmem[i_right_addr[ADDR_W-1:0]];
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= r_l_q * r_r_q;
    end

    // accumulate
    always_comb begin
        if (r_s2_first) begin
            n_acc = ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_acc <= n_acc;
        end
    end

    // floor shift and saturation to 32 bits
    assign shifted = r_acc >>> FRAC_BITS;
    assign upper   = shifted[ACC_W-1:DATA_W-1];
    assign fits    = (&upper) || !(|upper);

    always_comb begin
        n_res     = shifted[DATA_W-1:0];
        n_res_sat = 1'b0;
        if (!fits) begin
            n_res     = r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
            n_res_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_acc_done) begin
            r_res     <= n_res;
            r_res_sat <= n_res_sat;
        end
    end

    // pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s1_first  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s2_first  <= 1'b0;
            r_s2_last   <= 1'b0;
            r_acc_done  <= 1'b0;
            r_res_ready <= 1'b0;
        end else begin
            r_s1_v     <= i_cmd.mac_valid;
            r_s1_first <= i_cmd.mac_first;
            r_s1_last  <= i_cmd.mac_last;
            r_s2_v     <= r_s1_v;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_acc_done <= r_s2_v && r_s2_last;
            if (r_acc_done) begin
                r_res_ready <= 1'b1;
            end else if (i_cmd.emit) begin
                r_res_ready <= 1'b0;
            end
        end
    end

    // output register
    assign o_stat.res_ready = r_res_ready;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_product_value <= r_res;
            o_row_index     <= i_cmd.row;
            o_col_index     <= i_cmd.col;
            o_saturated     <= r_res_sat;
            o_status        <= STATUS_OK;
            o_last          <= i_cmd.last;
        end else if (i_cmd.emit_err) begin
            o_product_value <= '0;
            o_row_index     <= '0;
            o_col_index     <= '0;
            o_saturated     <= 1'b0;
            o_status        <= STATUS_MISMATCH;
            o_last          <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ dv/mme_checker.sv @@
// ----------------------------------------------------------------------------
// mme_checker: result checker of the matrix multiply engine
// Watches the configuration, element and result channels. It keeps its own
// copy of the size registers and operand stores, works out every product
// entry when a transfer completes both operands, and compares each result
// transfer field by field with the oldest entry still owed.
// ----------------------------------------------------------------------------
module mme_checker
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration channel
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // element channel
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_op,
    input  logic [DATA_W-1:0]        i_element_value,
    // result channel
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [DATA_W-1:0]        i_product_value,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_col_index,
    input  logic                     i_saturated,
    input  logic                     i_status,
    input  logic                     i_last,
    // summary to the top
    output int                       o_mismatches,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              sat;
        logic              status;
        logic              last;
    } t_product_entry;

    logic [DATA_W-1:0] a_elems [STORE_DEPTH];
    logic [DATA_W-1:0] b_elems [STORE_DEPTH];
    logic [CFG_W-1:0]  size_regs [4];
    int                a_fill;
    int                b_fill;
    int                mismatch_count;
    t_product_entry    product_entries [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        mismatch_count = 0;
        for (int n = 0; n < STORE_DEPTH; n++) begin
            a_elems[n] = '0;
            b_elems[n] = '0;
        end
    end

    // zero counts as one, anything above the limit as the limit
    function automatic int clamp_dim(input logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM) return MAX_DIM;
        return int'(r);
    endfunction

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : matmul
        int ar, ac, br, bc, i, j, k;
        logic signed [127:0] acc, scaled;
        t_product_entry entry;
        if (!i_rst_n) begin
            a_fill = 0;
            b_fill = 0;
            for (int n = 0; n < 4; n++) size_regs[n] = CFG_RESET;
            product_entries.delete();
        end else begin
            // result transfer against the oldest owed entry
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (product_entries.size() == 0) begin
                    $error("result transfer with nothing owed: value %0h row %0d col %0d",
                           i_product_value, i_row_index, i_col_index);
                    mismatch_count++;
                end else begin
                    entry = product_entries.pop_front();
                    check_field("product_value", entry.value, i_product_value);
                    check_field("row_index", DATA_W'(entry.row), DATA_W'(i_row_index));
                    check_field("col_index", DATA_W'(entry.col), DATA_W'(i_col_index));
                    check_field("saturated", DATA_W'(entry.sat), DATA_W'(i_saturated));
                    check_field("status", DATA_W'(entry.status), DATA_W'(i_status));
                    check_field("last", DATA_W'(entry.last), DATA_W'(i_last));
                end
            end

            // size register write
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1)
                size_regs[i_cfg_index] = i_cfg_data;

            // element transfer: load, then multiply once both operands are complete
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                ar = clamp_dim(size_regs[REG_A_ROWS]);
                ac = clamp_dim(size_regs[REG_A_COLS]);
                br = clamp_dim(size_regs[REG_B_ROWS]);
                bc = clamp_dim(size_regs[REG_B_COLS]);
                if (i_op == OP_LOAD_A) begin
                    if (a_fill < ar * ac) begin
                        a_elems[a_fill] = i_element_value;
                        a_fill++;
                    end
                end else if (b_fill < br * bc) begin
                    b_elems[b_fill] = i_element_value;
                    b_fill++;
                end

                if (a_fill >= ar * ac && b_fill >= br * bc) begin
                    a_fill = 0;
                    b_fill = 0;
                    if (ac != br) begin
                        entry = '0;
                        entry.status = STATUS_MISMATCH;
                        entry.last   = 1'b1;
                        product_entries.push_back(entry);
                    end else begin
                        for (i = 0; i < ar; i++) begin
                            for (j = 0; j < bc; j++) begin
                                // exact sum of full products, floor shift, then clip
                                acc = '0;
                                for (k = 0; k < ac; k++)
                                    acc = acc + $signed(a_elems[i * ac + k])
                                              * $signed(b_elems[k * bc + j]);
                                scaled = acc >>> FRAC_BITS;
                                entry.sat = 1'b1;
                                if (scaled > Q_MAX)      entry.value = SAT_MAX;
                                else if (scaled < Q_MIN) entry.value = SAT_MIN;
                                else begin
                                    entry.value = scaled[DATA_W-1:0];
                                    entry.sat   = 1'b0;
                                end
                                entry.row    = IDX_W'(i);
                                entry.col    = IDX_W'(j);
                                entry.status = STATUS_OK;
                                entry.last   = (i == ar - 1 && j == bc - 1);
                                product_entries.push_back(entry);
                            end
                        end
                    end
                end
            end
        end
        o_pending    <= product_entries.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the matrix multiply engine
// A short directed pass covers saturation both ways, floor rounding, dropped
// elements, clamped and zero sizes, inner dimension mismatch and a size
// shrink over a partial load. Random phases follow with mostly well-formed
// operand streams and random sizes under varying idle and stall pressure.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mme_pkg::*;

    localparam int MAX_DIM       = 8;
    localparam int FRAC_BITS     = 16;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 16;
    localparam int NUM_PHASES    = 9;
    localparam int TIMEOUT_NS    = 1_000_000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_A_ROWS;
    logic [CFG_W-1:0]         cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     in_op     = OP_LOAD_A;
    logic signed [DATA_W-1:0] in_value  = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] product_value;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic                     saturated;
    logic                     status;
    logic                     last_flag;

    int   mismatches;
    int   pending;
    int   items_sent = 0;
    int   gap_pct    = 0;
    int   stall_pct  = 0;
    logic hold_kick  = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;

    always #1 clk = ~clk;

    matrix_multiply_engine #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (in_op),
        .i_element_value (in_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_product_value (product_value),
        .o_row_index     (row_index),
        .o_col_index     (col_index),
        .o_saturated     (saturated),
        .o_status        (status),
        .o_last          (last_flag)
    );

    mme_checker #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (in_op),
        .i_element_value (in_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_product_value (product_value),
        .i_row_index     (row_index),
        .i_col_index     (col_index),
        .i_saturated     (saturated),
        .i_status        (status),
        .i_last          (last_flag),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        #(TIMEOUT_NS);
        $display("matrix_multiply_engine test failed");
        $finish;
    end

    // result side: long hold-off on request, random stall otherwise
    always @(posedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM) return MAX_DIM;
        return int'(r);
    endfunction

    // mostly small sizes, now and then zero, the limit or beyond it
    function automatic logic [CFG_W-1:0] rand_dim();
        case ($urandom_range(19, 0))
            0:       return '0;
            1:       return CFG_W'($urandom_range(15, MAX_DIM + 1));
            2:       return CFG_W'(MAX_DIM);
            default: return CFG_W'($urandom_range(3, 1));
        endcase
    endfunction

    function automatic logic rand_op();
        return ($urandom_range(1, 0) == 0) ? OP_LOAD_A : OP_LOAD_B;
    endfunction

    // extremes, full-range words, and values within +/-4.0
    function automatic logic [DATA_W-1:0] rand_element();
        case ($urandom_range(9, 0))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2, 3:    return $urandom();
            default: return DATA_W'($urandom_range(32'h0008_0000, 0)) - 32'h0004_0000;
        endcase
    endfunction

    // one element transfer; valid stays high into the next call unless a gap is drawn
    task automatic send_item(input logic op, input logic [DATA_W-1:0] value);
        if ($urandom_range(99, 0) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < gap_pct);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_value <= value;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
    endtask

    // both operands in random interleave, with the odd element to an already full side
    task automatic send_product(input int left_size, input int right_size);
        int   sent_a, sent_b;
        logic pick;
        sent_a = 0;
        sent_b = 0;
        while (sent_a < left_size || sent_b < right_size) begin
            if ((sent_a == left_size) != (sent_b == right_size) && $urandom_range(9, 0) == 0)
                send_item((sent_a == left_size) ? OP_LOAD_A : OP_LOAD_B, rand_element());
            if (sent_a == left_size)       pick = OP_LOAD_B;
            else if (sent_b == right_size) pick = OP_LOAD_A;
            else                           pick = rand_op();
            send_item(pick, rand_element());
            if (pick == OP_LOAD_A) sent_a++;
            else sent_b++;
        end
    endtask

    // stop sending and wait until every owed result has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four size registers back to back
    task automatic set_dims(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] ac,
                            input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bc);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [CFG_W-1:0]     vals [4];
        regs = '{REG_A_ROWS, REG_A_COLS, REG_B_ROWS, REG_B_COLS};
        vals = '{ar, ac, br, bc};
        for (int n = 0; n < 4; n++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[n];
            cfg_data  <= vals[n];
            do @(posedge clk); while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [DATA_W-1:0] dir_a [6];
        logic [DATA_W-1:0] dir_b [6];
        logic [CFG_W-1:0]  ar, ac, br, bc;
        int                lsz, rsz, start_count, burst;

        dir_a = '{SAT_MAX, SAT_MIN, SAT_MIN, 32'h0001_0000, 32'h0000_0001, 32'h0000_0000};
        dir_b = '{SAT_MAX, SAT_MAX, SAT_MIN, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1x1 products: clipping both ways, exact negative, floor of a tiny negative
        set_dims('0, 4'd1, 4'd1, '0);
        for (int n = 0; n < 6; n++) begin
            send_item(OP_LOAD_A, dir_a[n]);
            send_item(OP_LOAD_B, dir_b[n]);
        end
        // second A element finds A full and is dropped
        send_item(OP_LOAD_A, 32'h0003_0000);
        send_item(OP_LOAD_A, 32'hDEAD_BEEF);
        send_item(OP_LOAD_B, 32'hFFFE_8000);

        // inner dimensions differ: single error result
        wait_idle();
        set_dims(4'd1, 4'd2, 4'd3, 4'd1);
        send_product(2, 3);

        // A half loaded, B full; shrinking both sizes lets a dropped element complete
        send_item(OP_LOAD_A, 32'h0002_8000);
        send_item(OP_LOAD_B, 32'hFFFF_C000);
        send_item(OP_LOAD_B, rand_element());
        send_item(OP_LOAD_B, rand_element());
        wait_idle();
        set_dims(4'd1, 4'd1, 4'd1, 4'd1);
        send_item(OP_LOAD_B, rand_element());

        // random phases, cycling through the idle and stall mixes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            gap_pct   =  (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 38 : 0;
            stall_pct <= (ph % 4 == 2) ? 80 : (ph % 4 == 3) ? 38 : 0;
            if (ph == 0) begin
                // full 8x8 by 8x8; sizes above the limit clamp to it
                set_dims(4'd15, 4'd8, 4'd9, 4'd8);
                hold_kick <= ~hold_kick;
                send_product(MAX_DIM * MAX_DIM, MAX_DIM * MAX_DIM);
                // engine busy and output held: these back up at the input
                repeat (6) send_item(rand_op(), rand_element());
            end else begin
                ar = rand_dim();
                ac = rand_dim();
                br = ($urandom_range(4, 0) == 0) ? rand_dim() : ac;
                bc = rand_dim();
                set_dims(ar, ac, br, bc);
                lsz = clamp_dim(ar) * clamp_dim(ac);
                rsz = clamp_dim(br) * clamp_dim(bc);
                start_count = items_sent;
                while (items_sent - start_count < PHASE_ITEMS) begin
                    if ($urandom_range(6, 0) == 0) begin
                        // broken stream: a random fragment of a product
                        burst = $urandom_range(lsz + rsz - 1, 1);
                        repeat (burst) send_item(rand_op(), rand_element());
                    end else begin
                        send_product(lsz, rsz);
                    end
                    // sender pauses until all results are out: always in phase 1, now and then otherwise
                    if (ph == 1 || $urandom_range(5, 0) == 0)
                        wait_idle();
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("matrix_multiply_engine test passed");
        else
            $display("matrix_multiply_engine test failed");
        $finish;
    end

endmodule
